@@ sv/wheel_pi_pid_pwm_controller_core_defines.svh @@
// Assertion macros shared by the controller RTL.
`ifndef WHEEL_PI_PID_PWM_CONTROLLER_CORE_DEFINES_SVH
`define WHEEL_PI_PID_PWM_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define WPPC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("wppc: invariant violated");
// Consequent holds in the same cycle as the antecedent.
`define WPPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wppc: implication violated");
// Consequent holds in the cycle after the antecedent.
`define WPPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wppc: next-cycle implication violated");
`else
`define WPPC_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define WPPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define WPPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/wppc_pkg.sv @@
package wppc_pkg;

  // Channel count default
  localparam int NUM_WHEELS = 4;

  // Field widths
  localparam int WHEEL_W    = 2;
  localparam int ENC_W      = 16;
  localparam int TGT_W      = 32;
  localparam int DRIVE_W    = 14;
  localparam int DUTY_W     = 13;
  localparam int SGAIN_W    = 8;
  localparam int PGAIN_W    = 24;
  localparam int LIMIT_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Serial multiplier: gain bits walked one per cycle
  localparam int MUL_GAIN_W = 24;
  localparam int MUL_MAG_W  = 32;

  // Duty divider: quotient bits, dividend is twice as wide
  localparam int DIV_QUO_W  = 13;

  // Arithmetic constants
  localparam int PWM_FULL    = 7200;
  localparam int PI_LIMIT    = 7200;
  localparam int INTEG_LIMIT = 100000;
  localparam int DEAD_BAND   = 100;
  localparam int POS_SHIFT   = 8;
  localparam int FRAC_W      = 16;
  localparam int DZ_MAX      = 7199;

  // Register reset values
  localparam logic [SGAIN_W-1:0] SGAIN_RESET = 8'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd6900;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KI      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd7;

  // Status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

@@ sv/wppc_ser_mul.sv @@
// Shift-add multiplier: one gain bit per cycle, unsigned operands.
module wppc_ser_mul #(
  parameter int GAIN_W = wppc_pkg::MUL_GAIN_W,
  parameter int MAG_W  = wppc_pkg::MUL_MAG_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [GAIN_W-1:0]         gain,
  input  logic [MAG_W-1:0]          mag,
  output logic [GAIN_W+MAG_W-1:0]   prod,
  output wppc_pkg::unit_status_t    status
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [GAIN_W+MAG_W-1:0] acc;
  logic [MAG_W-1:0]        mag_hold;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    done;
  logic [MAG_W:0]          part_sum;

  // Add the multiplicand into the upper half when the current gain bit is set
  always_comb begin
    part_sum = {1'b0, acc[GAIN_W+MAG_W-1:GAIN_W]}
             + (acc[0] ? {1'b0, mag_hold} : {(MAG_W+1){1'b0}});
  end

  // Gain sits in the low half and shifts out as the product shifts in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc      <= {{MAG_W{1'b0}}, gain};
        mag_hold <= mag;
        cnt      <= CNT_W'(GAIN_W);
        busy     <= 1'b1;
      end else if (busy) begin
        acc <= {part_sum, acc[GAIN_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod        = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ sv/wppc_const_div.sv @@
// Restoring divider by a constant: one quotient bit per cycle.
// The dividend shifted right by QUO_W must be below DIVISOR.
module wppc_const_div #(
  parameter int QUO_W   = wppc_pkg::DIV_QUO_W,
  parameter int DIVISOR = wppc_pkg::PWM_FULL
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*QUO_W-1:0]      dividend,
  output logic [QUO_W-1:0]        quo,
  output wppc_pkg::unit_status_t  status
);

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic [QUO_W:0] DIV_K = (QUO_W+1)'(DIVISOR);

  logic [QUO_W-1:0] rem;
  logic [QUO_W-1:0] bits;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [QUO_W:0]   trial;
  logic [QUO_W:0]   diff;
  logic             take;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, bits[QUO_W-1]};
    diff  = trial - DIV_K;
    take  = (trial >= DIV_K);
  end

  // Dividend low bits shift out at the top while quotient bits enter below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[2*QUO_W-1:QUO_W];
        bits <= dividend[QUO_W-1:0];
        cnt  <= CNT_W'(QUO_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= take ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
        bits <= {bits[QUO_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo         = bits;
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ sv/wheel_pi_pid_pwm_controller_core.sv @@
// Channel   Handshake             Payload
// in        in_valid / in_stall   wheel, encoder_delta, target
// out       out_valid / out_stall wheel_out, drive_value, duty, forward, backward
// cfg       cfg_en                cfg_index, cfg_data
//
// One item at a time. A wheel index beyond the channel count skips the loops and reports zero drive.
// In velocity mode the bit-serial multiplier runs twice (five times in position mode),
// once more for the duty scaling, followed by the divider; drives inside the dead band
// skip those last two.
// Synchronous reset clears all wheel state and loads the register defaults.
// A finished beat waits in the output register; the next item is taken meanwhile.
`include "wheel_pi_pid_pwm_controller_core_defines.svh"

module wheel_pi_pid_pwm_controller_core #(
  parameter int NUM_WHEELS = wppc_pkg::NUM_WHEELS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wppc_pkg::WHEEL_W-1:0]          wheel,
  input  logic signed [wppc_pkg::ENC_W-1:0]     encoder_delta,
  input  logic signed [wppc_pkg::TGT_W-1:0]     target,
  // Output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wppc_pkg::WHEEL_W-1:0]          wheel_out,
  output logic signed [wppc_pkg::DRIVE_W-1:0]   drive_value,
  output logic [wppc_pkg::DUTY_W-1:0]           duty,
  output logic                                  forward,
  output logic                                  backward,
  // Configuration
  input  logic                                  cfg_en,
  input  logic [wppc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wppc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int WIDX   = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int GW     = wppc_pkg::MUL_GAIN_W;
  localparam int MW     = wppc_pkg::MUL_MAG_W;
  localparam int PW     = GW + MW;
  localparam int QW     = wppc_pkg::DIV_QUO_W;
  localparam int FRAC_W = wppc_pkg::FRAC_W;
  localparam int TERM_W = 41;
  localparam int SUM_W  = 44;
  localparam int DW     = wppc_pkg::DRIVE_W;
  localparam int UW     = wppc_pkg::DUTY_W;
  localparam int LW     = wppc_pkg::LIMIT_W;
  localparam int IW     = 18;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_PE     = 4'd2;
  localparam logic [3:0] S_PINT   = 4'd3;
  localparam logic [3:0] S_PTGT   = 4'd4;
  localparam logic [3:0] S_SE     = 4'd5;
  localparam logic [3:0] S_SD     = 4'd6;
  localparam logic [3:0] S_MSTART = 4'd7;
  localparam logic [3:0] S_MWAIT  = 4'd8;
  localparam logic [3:0] S_ACC    = 4'd9;
  localparam logic [3:0] S_LIM    = 4'd10;
  localparam logic [3:0] S_DZ     = 4'd11;
  localparam logic [3:0] S_DSTART = 4'd12;
  localparam logic [3:0] S_DWAIT  = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  // Multiplier jobs
  localparam logic [2:0] MS_PKP  = 3'd0;
  localparam logic [2:0] MS_PKI  = 3'd1;
  localparam logic [2:0] MS_PKD  = 3'd2;
  localparam logic [2:0] MS_SKP  = 3'd3;
  localparam logic [2:0] MS_SKI  = 3'd4;
  localparam logic [2:0] MS_DUTY = 3'd5;

  // Clamp bounds
  localparam logic signed [32:0]      INTEG_HI = 33'(wppc_pkg::INTEG_LIMIT);
  localparam logic signed [32:0]      INTEG_LO = -INTEG_HI;
  localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_W'(64'sd2147483648);
  localparam logic signed [SUM_W-1:0] ACC_HI   = SUM_W'(wppc_pkg::PI_LIMIT);
  localparam logic signed [SUM_W-1:0] ACC_LO   = -ACC_HI;
  localparam logic [UW-1:0]           PWM_K    = UW'(wppc_pkg::PWM_FULL);
  localparam logic [LW-1:0]           DZ_TOP   = LW'(wppc_pkg::DZ_MAX);
  localparam logic [UW-1:0]           BAND     = UW'(wppc_pkg::DEAD_BAND);

  // Magnitude of a 33-bit signed value; always fits 32 bits here
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    mag33 = v[32] ? n[31:0] : v[31:0];
  endfunction

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  // Configuration registers
  logic                    loop_mode;
  logic [7:0]              speed_prop_gain;
  logic [7:0]              speed_integ_gain;
  logic [23:0]             pos_prop_gain;
  logic [23:0]             pos_integ_gain;
  logic [23:0]             pos_deriv_gain;
  logic [LW-1:0]           output_limit;
  logic [LW-1:0]           dead_zone_offset;

  // Per-wheel state
  logic signed [DW-1:0]    pi_accumulator      [NUM_WHEELS];
  logic signed [31:0]      last_speed_error    [NUM_WHEELS];
  logic [31:0]             position_total      [NUM_WHEELS];
  logic signed [IW-1:0]    position_integral   [NUM_WHEELS];
  logic signed [31:0]      last_position_error [NUM_WHEELS];

  // Sequencer and working registers
  logic [3:0]              state;
  logic [2:0]              mstep;
  logic                    msign;
  logic [WIDX-1:0]         widx;
  logic [1:0]              wheel_reg;
  logic signed [15:0]      enc_reg;
  logic signed [31:0]      tgt_reg;
  logic signed [31:0]      pe_reg;
  logic signed [IW-1:0]    integ_reg;
  logic signed [32:0]      diff_reg;
  logic signed [31:0]      e_reg;
  logic signed [SUM_W-1:0] sum_reg;
  logic signed [DW-1:0]    v_reg;
  logic [UW-1:0]           mag_reg;
  logic [UW-1:0]           duty_w;
  logic                    fwd_w;
  logic                    bwd_w;

  // Combinational datapath
  logic                    in_range;
  logic                    out_free;
  logic [31:0]             pos_cur;
  logic signed [DW-1:0]    acc_cur;
  logic signed [32:0]      pe_diff;
  logic signed [32:0]      isum;
  logic signed [IW-1:0]    integ_clamped;
  logic signed [32:0]      pd_diff;
  logic signed [31:0]      sum_sat;
  logic signed [31:0]      sum_shr;
  logic signed [32:0]      e_diff;
  logic signed [32:0]      sd_diff;
  logic signed [SUM_W-1:0] acc_diff;
  logic signed [DW-1:0]    acc_clamped;
  logic signed [DW:0]      lim15;
  logic signed [DW:0]      acc15;
  logic signed [DW:0]      v15;
  logic signed [DW-1:0]    v14;
  logic signed [DW-1:0]    vneg;
  logic [LW-1:0]           dz_eff;
  logic [GW-1:0]           op_gain;
  logic [MW-1:0]           op_mag;
  logic                    op_sign;
  logic [TERM_W-1:0]       tmag;
  logic signed [SUM_W-1:0] term_ext;
  logic                    mul_start;
  logic                    div_start;
  logic [PW-1:0]           mul_prod;
  logic [QW-1:0]           div_quo;
  wppc_pkg::unit_status_t  mul_st;
  wppc_pkg::unit_status_t  div_st;

  assign in_range  = ({30'd0, wheel} < 32'(NUM_WHEELS));
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign mul_start = (state == S_MSTART);
  assign div_start = (state == S_DSTART);

  always_comb begin
    pos_cur = position_total[widx];
    acc_cur = pi_accumulator[widx];

    // Position error against the updated total
    pe_diff = $signed({pos_cur[31], pos_cur}) - $signed({tgt_reg[31], tgt_reg});

    // Integral with clamp
    isum = $signed({{(33-IW){position_integral[widx][IW-1]}}, position_integral[widx]})
         + $signed({pe_reg[31], pe_reg});
    if (isum > INTEG_HI) begin
      integ_clamped = INTEG_HI[IW-1:0];
    end else if (isum < INTEG_LO) begin
      integ_clamped = INTEG_LO[IW-1:0];
    end else begin
      integ_clamped = isum[IW-1:0];
    end
    pd_diff = $signed({pe_reg[31], pe_reg})
            - $signed({last_position_error[widx][31], last_position_error[widx]});

    // PID sum to 32 bits, then floor shift
    if (sum_reg > SUM_MAX) begin
      sum_sat = 32'sh7fff_ffff;
    end else if (sum_reg < SUM_MIN) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum_reg[31:0];
    end
    sum_shr = sum_sat >>> wppc_pkg::POS_SHIFT;

    // Speed error and its change
    e_diff  = $signed({{17{enc_reg[15]}}, enc_reg}) - $signed({tgt_reg[31], tgt_reg});
    sd_diff = $signed({e_reg[31], e_reg})
            - $signed({last_speed_error[widx][31], last_speed_error[widx]});

    // Incremental PI accumulator with clamp
    acc_diff = $signed({{(SUM_W-DW){acc_cur[DW-1]}}, acc_cur}) - sum_reg;
    if (acc_diff > ACC_HI) begin
      acc_clamped = ACC_HI[DW-1:0];
    end else if (acc_diff < ACC_LO) begin
      acc_clamped = ACC_LO[DW-1:0];
    end else begin
      acc_clamped = acc_diff[DW-1:0];
    end

    // Output limit and magnitude
    lim15 = $signed({2'b00, output_limit});
    acc15 = $signed({acc_cur[DW-1], acc_cur});
    if (acc15 > lim15) begin
      v15 = lim15;
    end else if (acc15 < -lim15) begin
      v15 = -lim15;
    end else begin
      v15 = acc15;
    end
    v14  = v15[DW-1:0];
    vneg = -v14;

    dz_eff = (dead_zone_offset > DZ_TOP) ? DZ_TOP : dead_zone_offset;

    // Multiplier operands for the current job
    unique case (mstep)
      MS_PKP: begin
        op_gain = pos_prop_gain;
        op_mag  = mag33({pe_reg[31], pe_reg});
        op_sign = pe_reg[31];
      end
      MS_PKI: begin
        op_gain = pos_integ_gain;
        op_mag  = mag33({{(33-IW){integ_reg[IW-1]}}, integ_reg});
        op_sign = integ_reg[IW-1];
      end
      MS_PKD: begin
        op_gain = pos_deriv_gain;
        op_mag  = mag33(diff_reg);
        op_sign = diff_reg[32];
      end
      MS_SKP: begin
        op_gain = GW'(speed_prop_gain);
        op_mag  = mag33(diff_reg);
        op_sign = diff_reg[32];
      end
      MS_SKI: begin
        op_gain = GW'(speed_integ_gain);
        op_mag  = mag33({e_reg[31], e_reg});
        op_sign = e_reg[31];
      end
      default: begin
        op_gain = GW'(PWM_K - dz_eff);
        op_mag  = MW'(mag_reg);
        op_sign = 1'b0;
      end
    endcase

    // Position gains carry fraction bits: truncate the magnitude
    if (mstep == MS_PKP || mstep == MS_PKI || mstep == MS_PKD) begin
      tmag = TERM_W'(mul_prod >> FRAC_W);
    end else begin
      tmag = mul_prod[TERM_W-1:0];
    end
    term_ext = $signed({{(SUM_W-TERM_W){1'b0}}, tmag});
  end

  wppc_ser_mul #(
    .GAIN_W (GW),
    .MAG_W  (MW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .gain   (op_gain),
    .mag    (op_mag),
    .prod   (mul_prod),
    .status (mul_st)
  );

  wppc_const_div #(
    .QUO_W   (QW),
    .DIVISOR (wppc_pkg::PWM_FULL)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[2*QW-1:0]),
    .quo      (div_quo),
    .status   (div_st)
  );

  // Configuration, wheel state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode        <= 1'b0;
      speed_prop_gain  <= wppc_pkg::SGAIN_RESET;
      speed_integ_gain <= wppc_pkg::SGAIN_RESET;
      pos_prop_gain    <= '0;
      pos_integ_gain   <= '0;
      pos_deriv_gain   <= '0;
      output_limit     <= wppc_pkg::LIMIT_RESET;
      dead_zone_offset <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pi_accumulator[i]      <= '0;
        last_speed_error[i]    <= '0;
        position_total[i]      <= '0;
        position_integral[i]   <= '0;
        last_position_error[i] <= '0;
      end
      state <= S_IDLE;
      mstep <= MS_PKP;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          wppc_pkg::CFG_LOOP_MODE:  loop_mode        <= cfg_data[0];
          wppc_pkg::CFG_SPEED_KP:   speed_prop_gain  <= cfg_data[7:0];
          wppc_pkg::CFG_SPEED_KI:   speed_integ_gain <= cfg_data[7:0];
          wppc_pkg::CFG_POS_KP:     pos_prop_gain    <= cfg_data[23:0];
          wppc_pkg::CFG_POS_KI:     pos_integ_gain   <= cfg_data[23:0];
          wppc_pkg::CFG_POS_KD:     pos_deriv_gain   <= cfg_data[23:0];
          wppc_pkg::CFG_OUTPUT_LIM: output_limit     <= cfg_data[LW-1:0];
          wppc_pkg::CFG_DEAD_ZONE:  dead_zone_offset <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            wheel_reg <= wheel;
            enc_reg   <= encoder_delta;
            tgt_reg   <= target;
            widx      <= WIDX'(wheel);
            if (in_range) begin
              state <= S_LOAD;
            end else begin
              v_reg  <= '0;
              duty_w <= '0;
              fwd_w  <= 1'b0;
              bwd_w  <= 1'b0;
              state  <= S_FIN;
            end
          end
        end
        S_LOAD: begin
          // Position total always advances
          position_total[widx] <= pos_cur + {{16{enc_reg[15]}}, enc_reg};
          state <= loop_mode ? S_PE : S_SE;
        end
        S_PE: begin
          pe_reg <= sat33(pe_diff);
          state  <= S_PINT;
        end
        S_PINT: begin
          integ_reg <= integ_clamped;
          diff_reg  <= pd_diff;
          sum_reg   <= '0;
          mstep     <= MS_PKP;
          state     <= S_MSTART;
        end
        S_MSTART: begin
          msign <= op_sign;
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_st.done) begin
            sum_reg <= msign ? (sum_reg - term_ext) : (sum_reg + term_ext);
            unique case (mstep)
              MS_PKP: begin
                mstep <= MS_PKI;
                state <= S_MSTART;
              end
              MS_PKI: begin
                mstep <= MS_PKD;
                state <= S_MSTART;
              end
              MS_PKD:  state <= S_PTGT;
              MS_SKP: begin
                mstep <= MS_SKI;
                state <= S_MSTART;
              end
              MS_SKI:  state <= S_ACC;
              MS_DUTY: state <= S_DSTART;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PTGT: begin
          // Negated PID output becomes the speed target
          tgt_reg                   <= -sum_shr;
          position_integral[widx]   <= integ_reg;
          last_position_error[widx] <= pe_reg;
          state                     <= S_SE;
        end
        S_SE: begin
          e_reg <= sat33(e_diff);
          state <= S_SD;
        end
        S_SD: begin
          diff_reg <= sd_diff;
          sum_reg  <= '0;
          mstep    <= MS_SKP;
          state    <= S_MSTART;
        end
        S_ACC: begin
          pi_accumulator[widx]   <= acc_clamped;
          last_speed_error[widx] <= e_reg;
          state                  <= S_LIM;
        end
        S_LIM: begin
          v_reg   <= v14;
          mag_reg <= v14[DW-1] ? vneg[UW-1:0] : v14[UW-1:0];
          state   <= S_DZ;
        end
        S_DZ: begin
          // Drop small drives to zero duty and no direction
          if (mag_reg < BAND) begin
            duty_w <= '0;
            fwd_w  <= 1'b0;
            bwd_w  <= 1'b0;
            state  <= S_FIN;
          end else begin
            mstep <= MS_DUTY;
            state <= S_MSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_st.done) begin
            duty_w <= div_quo + dz_eff;
            fwd_w  <= !v_reg[DW-1];
            bwd_w  <= v_reg[DW-1];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid   <= 1'b1;
      wheel_out   <= wheel_reg;
      drive_value <= v_reg;
      duty        <= duty_w;
      forward     <= fwd_w;
      backward    <= bwd_w;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `WPPC_ASSERT_ALWAYS(a_units_exclusive, clk, rst, !(mul_st.busy && div_st.busy))
  `WPPC_ASSERT_IMPLY(a_mul_running, clk, rst, state == S_MWAIT, mul_st.busy || mul_st.done)
  `WPPC_ASSERT_IMPLY(a_div_running, clk, rst, state == S_DWAIT, div_st.busy || div_st.done)
  `WPPC_ASSERT_NEXT(a_fin_loads, clk, rst, state == S_FIN && out_free, out_valid)
  `WPPC_ASSERT_IMPLY(a_pins_follow_duty, clk, rst, out_valid, ((forward || backward) == (duty != '0)) && !(forward && backward))

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wppc_pkg::*;

  typedef longint unsigned u64_t;

  // One drive command as the block should report it
  typedef struct {
    logic [WHEEL_W-1:0]        wheel;
    logic signed [DRIVE_W-1:0] drive;
    logic [DUTY_W-1:0]         duty;
    logic                      fwd;
    logic                      bwd;
  } drive_result_t;

  localparam logic signed [ENC_W-1:0] ENC_MIN = {1'b1, {(ENC_W-1){1'b0}}};
  localparam logic signed [ENC_W-1:0] ENC_MAX = {1'b0, {(ENC_W-1){1'b1}}};
  localparam logic signed [TGT_W-1:0] TGT_MIN = {1'b1, {(TGT_W-1){1'b0}}};
  localparam logic signed [TGT_W-1:0] TGT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
  localparam longint WORD_MIN = -longint'(32'h8000_0000);
  localparam longint WORD_MAX = longint'(32'h7FFF_FFFF);
  localparam logic [LIMIT_W-1:0] FIELD13_MAX = '1;
  localparam logic [LIMIT_W-1:0] LIM_FULL = LIMIT_W'(PI_LIMIT);
  localparam logic [LIMIT_W-1:0] DZ_TOP = LIMIT_W'(DZ_MAX);
  localparam logic [PGAIN_W-1:0] PGAIN_MAX = '1;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 1500;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 102;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [WHEEL_W-1:0]          wheel = '0;
  logic signed [ENC_W-1:0]     encoder_delta = '0;
  logic signed [TGT_W-1:0]     target = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [WHEEL_W-1:0]          wheel_out;
  logic signed [DRIVE_W-1:0]   drive_value;
  logic [DUTY_W-1:0]           duty;
  logic                        forward;
  logic                        backward;
  logic                        cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // Register copy, at reset values
  logic                  loop_mode_q = 1'b0;
  logic [SGAIN_W-1:0]    speed_kp_q = SGAIN_RESET;
  logic [SGAIN_W-1:0]    speed_ki_q = SGAIN_RESET;
  logic [PGAIN_W-1:0]    pos_kp_q = '0;
  logic [PGAIN_W-1:0]    pos_ki_q = '0;
  logic [PGAIN_W-1:0]    pos_kd_q = '0;
  logic [LIMIT_W-1:0]    out_limit_q = LIMIT_RESET;
  logic [LIMIT_W-1:0]    dead_zone_q = '0;

  // Per-wheel loop state
  int pi_acc_st [NUM_WHEELS] = '{default: 0};
  int speed_err_st [NUM_WHEELS] = '{default: 0};
  int pos_st [NUM_WHEELS] = '{default: 0};
  int integ_st [NUM_WHEELS] = '{default: 0};
  int pos_err_st [NUM_WHEELS] = '{default: 0};

  drive_result_t pending_drives [$];
  int mismatch_count = 0;
  int beats_checked = 0;
  int idle_pct = 21;
  int stall_pct = 21;
  int hold_requests = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  wheel_pi_pid_pwm_controller_core u_dut (.*);

  function automatic longint clamp_wide(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint sat_word(longint v);
    return clamp_wide(v, WORD_MIN, WORD_MAX);
  endfunction

  // Q16 gain times x, truncated toward zero
  function automatic longint scale_q16(logic [PGAIN_W-1:0] gain, longint x);
    u64_t mag;
    u64_t prod;
    mag = (x < 0) ? u64_t'(-x) : u64_t'(x);
    prod = (u64_t'(gain) * mag) >> FRAC_W;
    return (x < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // Advance one wheel's loops and map the drive to PWM
  function automatic drive_result_t predict_drive(logic [WHEEL_W-1:0] w,
                                                  logic signed [ENC_W-1:0] enc,
                                                  logic signed [TGT_W-1:0] tgt);
    longint goal, pe, integ, sum, e, inc, acc, lim, v, mag, dz;
    drive_result_t r;
    r.wheel = w;
    r.duty = '0;
    r.fwd = 1'b0;
    r.bwd = 1'b0;
    pos_st[w] = pos_st[w] + int'(enc);
    goal = longint'(tgt);
    // Position loop feeds the speed loop target
    if (loop_mode_q) begin
      pe = sat_word(longint'(pos_st[w]) - goal);
      integ = clamp_wide(longint'(integ_st[w]) + pe, -INTEG_LIMIT, INTEG_LIMIT);
      sum = scale_q16(pos_kp_q, pe) + scale_q16(pos_ki_q, integ)
          + scale_q16(pos_kd_q, pe - longint'(pos_err_st[w]));
      integ_st[w] = int'(integ);
      pos_err_st[w] = int'(pe);
      goal = -(sat_word(sum) >>> POS_SHIFT);
    end
    // Incremental speed PI
    e = sat_word(longint'(enc) - goal);
    inc = longint'(speed_kp_q) * (e - longint'(speed_err_st[w])) + longint'(speed_ki_q) * e;
    acc = clamp_wide(longint'(pi_acc_st[w]) - inc, -PI_LIMIT, PI_LIMIT);
    pi_acc_st[w] = int'(acc);
    speed_err_st[w] = int'(e);
    lim = longint'(out_limit_q);
    v = clamp_wide(acc, -lim, lim);
    mag = (v < 0) ? -v : v;
    if (mag >= DEAD_BAND) begin
      dz = (dead_zone_q > DZ_MAX) ? DZ_MAX : longint'(dead_zone_q);
      r.duty = DUTY_W'(mag * (PWM_FULL - dz) / PWM_FULL + dz);
      r.fwd = (v > 0);
      r.bwd = (v < 0);
    end
    r.drive = v[DRIVE_W-1:0];
    return r;
  endfunction

  // Offer one sample, hold it until accepted, then record its drive
  task automatic send_sample(input logic [WHEEL_W-1:0] w, input logic signed [ENC_W-1:0] enc,
                             input logic signed [TGT_W-1:0] tgt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    wheel <= w;
    encoder_delta <= enc;
    target <= tgt;
    do @(posedge clk); while (in_stall);
    pending_drives.push_back(predict_drive(w, enc, tgt));
    @(negedge clk);
  endtask

  // Set one wheel's PI output exactly; needs Kp 0, Ki 1 in speed mode
  task automatic drive_to(input logic [WHEEL_W-1:0] w, input int level);
    send_sample(w, '0, TGT_W'(level - pi_acc_st[w]));
  endtask

  // Drop valid and wait until every drive has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_LOOP_MODE:  loop_mode_q = data[0];
      CFG_SPEED_KP:   speed_kp_q = data[SGAIN_W-1:0];
      CFG_SPEED_KI:   speed_ki_q = data[SGAIN_W-1:0];
      CFG_POS_KP:     pos_kp_q = data[PGAIN_W-1:0];
      CFG_POS_KI:     pos_ki_q = data[PGAIN_W-1:0];
      CFG_POS_KD:     pos_kd_q = data[PGAIN_W-1:0];
      CFG_OUTPUT_LIM: out_limit_q = data[LIMIT_W-1:0];
      CFG_DEAD_ZONE:  dead_zone_q = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic mode, input logic [SGAIN_W-1:0] skp,
                           input logic [SGAIN_W-1:0] ski, input logic [PGAIN_W-1:0] pkp,
                           input logic [PGAIN_W-1:0] pki, input logic [PGAIN_W-1:0] pkd,
                           input logic [LIMIT_W-1:0] lim, input logic [LIMIT_W-1:0] dz);
    settle();
    write_reg(CFG_LOOP_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_SPEED_KP, CFG_DATA_W'(skp));
    write_reg(CFG_SPEED_KI, CFG_DATA_W'(ski));
    write_reg(CFG_POS_KP, pkp);
    write_reg(CFG_POS_KI, pki);
    write_reg(CFG_POS_KD, pkd);
    write_reg(CFG_OUTPUT_LIM, CFG_DATA_W'(lim));
    write_reg(CFG_DEAD_ZONE, CFG_DATA_W'(dz));
  endtask

  function automatic logic [SGAIN_W-1:0] pick_speed_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return SGAIN_W'($urandom_range(255));
      default: return SGAIN_W'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [PGAIN_W-1:0] pick_pos_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return PGAIN_MAX;
      2: return PGAIN_W'($urandom);
      default: return PGAIN_W'($urandom_range(1 << 17));
    endcase
  endfunction

  task automatic shuffle_settings();
    logic [LIMIT_W-1:0] lim, dz;
    case ($urandom_range(7))
      0: lim = '0;
      1: lim = LIM_FULL;
      2: lim = FIELD13_MAX;
      3: lim = LIMIT_RESET;
      4: lim = LIMIT_W'($urandom_range(8191));
      default: lim = LIMIT_W'($urandom_range(7200, 100));
    endcase
    case ($urandom_range(7))
      0: dz = '0;
      1: dz = DZ_TOP;
      2: dz = FIELD13_MAX;
      3, 4: dz = LIMIT_W'($urandom_range(8191));
      default: dz = LIMIT_W'($urandom_range(1000));
    endcase
    configure(1'($urandom_range(1)), pick_speed_gain(), pick_speed_gain(), pick_pos_gain(),
              pick_pos_gain(), pick_pos_gain(), lim, dz);
  endtask

  // Mostly samples that track the wheel, some wild ones
  task automatic random_sample();
    logic [WHEEL_W-1:0] w;
    logic signed [ENC_W-1:0] enc;
    longint base, aim;
    w = WHEEL_W'($urandom_range(NUM_WHEELS - 1));
    case ($urandom_range(19))
      0, 1, 2: enc = ENC_W'($urandom);
      3: begin
        case ($urandom_range(3))
          0: enc = ENC_MIN;
          1: enc = ENC_MAX;
          2: enc = '0;
          default: enc = '1;
        endcase
      end
      default: enc = ENC_W'(int'($urandom_range(400)) - 200);
    endcase
    base = loop_mode_q ? longint'(pos_st[w]) + longint'(enc) : longint'(enc);
    case ($urandom_range(19))
      0, 1: aim = int'($urandom);
      2: begin
        case ($urandom_range(3))
          0: aim = longint'(TGT_MIN);
          1: aim = longint'(TGT_MAX);
          2: aim = 0;
          default: aim = -1;
        endcase
      end
      3, 4, 5: aim = int'($urandom_range(10000)) - 5000;
      default: aim = base + int'($urandom_range(600)) - 300;
    endcase
    send_sample(w, enc, TGT_W'(aim));
  endtask

  // Register defaults straight out of reset, saturated drives
  task automatic check_reset_defaults();
    send_sample(0, ENC_MAX, '0);
    send_sample(1, ENC_MIN, '0);
    send_sample(2, '0, TGT_MAX);
    send_sample(3, ENC_MIN, TGT_MIN);
  endtask

  // Drives on both sides of the dead band
  task automatic check_dead_band();
    configure(1'b0, 0, 1, 0, 0, 0, LIM_FULL, 500);
    drive_to(0, 99);
    drive_to(0, 100);
    drive_to(0, -99);
    drive_to(0, -100);
    drive_to(0, 0);
  endtask

  // Oversized limit and dead zone, zero limit, saturated speed error
  task automatic check_clamps();
    configure(1'b0, 0, 1, 0, 0, 0, FIELD13_MAX, FIELD13_MAX);
    drive_to(1, PI_LIMIT);
    drive_to(1, -PI_LIMIT);
    configure(1'b0, 0, 1, 0, 0, 0, '0, '0);
    drive_to(2, 150);
    configure(1'b0, '1, '1, 0, 0, 0, LIM_FULL, DZ_TOP);
    send_sample(3, ENC_MAX, TGT_MIN);
    send_sample(3, ENC_MIN, TGT_MAX);
  endtask

  // Cascaded loop: saturated sum, integral clamp, then moderate gains
  task automatic check_position_loop();
    int i;
    int step;
    configure(1'b1, 1, 1, PGAIN_MAX, PGAIN_MAX, PGAIN_MAX, LIM_FULL, 100);
    send_sample(0, ENC_MAX, TGT_MIN);
    send_sample(0, ENC_MIN, TGT_MAX);
    repeat (3) send_sample(1, 1000, -200000);
    configure(1'b1, 2, 1, 65536, 655, 6554, LIMIT_RESET, 300);
    for (i = 0; i < 4; i++) begin
      step = i * 60 - 90;
      send_sample(2, ENC_W'(step), TGT_W'(pos_st[2] + step - 400 + i * 300));
    end
  endtask

  // Random phases with fresh settings; one without idling, one under back-pressure
  task automatic check_random_traffic();
    int phase, n;
    for (phase = 0; phase < PHASES; phase++) begin
      shuffle_settings();
      idle_pct = (phase == 3) ? 0 : 21;
      stall_pct = (phase == 3) ? 0 : 21;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 7 && n == 6) hold_requests++;
        random_sample();
      end
    end
    idle_pct = 21;
    stall_pct = 21;
  endtask

  task automatic flag_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t beat %0d %s: expected %0d, actual %0d", $time, beats_checked, name,
                 want, got);
    end
  endtask

  // Receiver: random stall, plus a long hold when asked
  initial begin : receiver
    int served, left;
    served = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each output beat with the oldest pending drive
  always @(posedge clk) begin : check_drives
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t unexpected beat: wheel %0d drive %0d duty %0d", $time, wheel_out,
                   drive_value, duty);
      end else begin
        want = pending_drives.pop_front();
        flag_field("wheel_out", longint'(want.wheel), longint'(wheel_out));
        flag_field("drive_value", longint'(want.drive), longint'(drive_value));
        flag_field("duty", longint'(want.duty), longint'(duty));
        flag_field("forward", longint'(want.fwd), longint'(forward));
        flag_field("backward", longint'(want.bwd), longint'(backward));
      end
      beats_checked++;
    end
  end

  // Count cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_reset_defaults();
    check_dead_band();
    check_clamps();
    check_position_loop();
    check_random_traffic();
    settle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/wppc_pkg.sv
sv/wppc_ser_mul.sv
sv/wppc_const_div.sv
sv/wheel_pi_pid_pwm_controller_core.sv
dv/testbench.sv
